// ----- src/loser_tree_replay_top_defines.svh -----
// assertion macros for the loser tree replay block
// used by loser_tree_replay_top; expects clk and arst_n in scope
`ifndef LOSER_TREE_REPLAY_TOP_DEFINES_SVH
`define LOSER_TREE_REPLAY_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define LTR_CHECK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ltr check failed: %m");
`define LTR_CHECK_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("ltr check failed: %m");
`else
`define LTR_CHECK(label, prop)
`define LTR_CHECK_ALWAYS(label, prop)
`endif
`endif

// ----- src/ltr_pkg.sv -----
// shared constants, types and helpers for the loser tree replay block
// no dependencies
`default_nettype none
package ltr_pkg;
	localparam int MAX_LEAVES = 16;
	localparam int KEY_W = 32;
	localparam int ACT_W = 2;
	localparam int NODE_W = $clog2(MAX_LEAVES);
	localparam int CNT_W = NODE_W + 1;
	localparam int CNT_MIN = 2;
	localparam int CNT_LIMIT = (MAX_LEAVES < 16) ? MAX_LEAVES : 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_BUILD = 2'd1;
	localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd2;

	typedef struct packed {
		logic we;
		logic [NODE_W-1:0] waddr;
		logic [KEY_W-1:0] wdata;
		logic [NODE_W-1:0] raddr;
	} leaf_req_t;

	typedef struct packed {
		logic we;
		logic [NODE_W-1:0] waddr;
		logic [NODE_W-1:0] wdata;
		logic [NODE_W-1:0] raddr;
	} node_req_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] node_value;
		logic [NODE_W-1:0] node_index;
		logic last;
	} out_word_t;

	// smallest power of two not below v
	function automatic logic [CNT_W-1:0] span_of(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] t;
		t = CNT_W'(1);
		for (int b = 0; b < CNT_W; b++) begin
			if (t < v) begin
				t = t << 1;
			end
		end
		return t;
	endfunction
endpackage
`default_nettype wire

// ----- src/ltr_item_if.sv -----
// input channel of the loser tree replay block
// depends on ltr_pkg
`default_nettype none
interface ltr_item_if;
	import ltr_pkg::*;
	logic valid;
	logic ready;
	logic [ACT_W-1:0] action;
	logic [NODE_W-1:0] leaf;
	logic signed [KEY_W-1:0] value;

	modport source (output valid, output action, output leaf, output value, input ready);
	modport sink (input valid, input action, input leaf, input value, output ready);
endinterface
`default_nettype wire

// ----- src/ltr_result_if.sv -----
// result channel of the loser tree replay block
// depends on ltr_pkg
`default_nettype none
interface ltr_result_if;
	import ltr_pkg::*;
	logic valid;
	logic ready;
	logic signed [KEY_W-1:0] node_value;
	logic [NODE_W-1:0] node_index;
	logic last;

	modport source (output valid, output node_value, output node_index, output last,
		input ready);
	modport sink (input valid, input node_value, input node_index, input last,
		output ready);
endinterface
`default_nettype wire

// ----- src/ltr_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module ltr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- src/ltr_ctrl.sv -----
// sequencer: leaf loads, tournament build, replay climb and node dump
// depends on ltr_pkg, ltr_item_if; drives the leaf and node rams
`default_nettype none
module ltr_ctrl (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ltr_pkg::CNT_W-1:0] cfg_wdata,
	ltr_item_if.sink item,
	output ltr_pkg::leaf_req_t leaf_req,
	input logic [ltr_pkg::KEY_W-1:0] leaf_rdata,
	output ltr_pkg::node_req_t node_req,
	input logic [ltr_pkg::NODE_W-1:0] node_rdata,
	input logic [ltr_pkg::FIFO_CNT_W-1:0] fifo_cnt,
	output logic push_vld,
	output ltr_pkg::out_word_t push_word
);
	import ltr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_BCHK = 3'd1;
	localparam logic [2:0] ST_BKA = 3'd2;
	localparam logic [2:0] ST_BKB = 3'd3;
	localparam logic [2:0] ST_CLIMB = 3'd4;
	localparam logic [2:0] ST_CNODE = 3'd5;
	localparam logic [2:0] ST_CKEY = 3'd6;
	localparam logic [2:0] ST_DUMP = 3'd7;

	function automatic logic [NODE_W-1:0] parent_of(input logic [NODE_W-1:0] i,
		input logic [CNT_W-1:0] t, input logic [CNT_W-1:0] l);
		logic [CNT_W:0] pos;
		if ({1'b0, i} < l) begin
			pos = {2'b00, i} + {1'b0, t};
		end else begin
			pos = {2'b00, i} - {2'b00, l[CNT_W-1:1]} + {2'b00, t[CNT_W-1:1]};
		end
		return pos[NODE_W:1];
	endfunction

	logic [2:0] state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] span_q;
	logic [CNT_W-1:0] low_q;
	logic [MAX_LEAVES-1:0] nvalid_q;
	logic building_q;
	logic [CNT_W-1:0] bi_q;
	logic [CNT_W-1:0] dk_q;
	logic [NODE_W-1:0] q_q;
	logic [NODE_W-1:0] cand_q;
	logic [KEY_W-1:0] cand_key_q;
	logic [KEY_W-1:0] key_a_q;
	logic [NODE_W-1:0] stored_q;
	logic v_s1;
	logic v_s2;
	logic [NODE_W-1:0] idx_s1;
	logic [NODE_W-1:0] idx_s2;
	logic last_s1;
	logic last_s2;
	logic nv_s1;
	logic nv_s2;

	logic item_fire;
	logic leaf_in_range;
	logic pair_less;
	logic climb_less;
	logic [NODE_W-1:0] bi_lo;
	logic [NODE_W-1:0] bi_next;
	logic single;
	logic [NODE_W-1:0] pair_node;
	logic store_here;
	logic [FIFO_CNT_W-1:0] inflight;
	logic dump_issue;
	logic dump_done;
	logic [CNT_W-1:0] cfg_count;
	logic [CNT_W-1:0] cfg_span;
	logic [CNT_W-1:0] cfg_low;

	assign item.ready = (state_q == ST_IDLE);
	assign item_fire = item.valid && item.ready;
	assign leaf_in_range = {1'b0, item.leaf} < count_q;
	assign pair_less = $signed(key_a_q) < $signed(leaf_rdata);
	assign climb_less = $signed(leaf_rdata) < $signed(cand_key_q);
	assign bi_lo = bi_q[NODE_W-1:0];
	assign bi_next = bi_lo + NODE_W'(1);
	assign single = (bi_q == low_q) && count_q[0];
	assign pair_node = parent_of(bi_lo, span_q, low_q);
	assign store_here = (q_q == '0) || !nvalid_q[q_q];
	assign inflight = fifo_cnt + FIFO_CNT_W'(v_s1) + FIFO_CNT_W'(v_s2);
	assign dump_issue = (state_q == ST_DUMP) && (dk_q < count_q)
		&& (inflight < FIFO_CNT_W'(FIFO_DEPTH));
	assign dump_done = (state_q == ST_DUMP) && (dk_q == count_q) && !v_s1 && !v_s2;

	always_comb begin
		if (cfg_wdata < CNT_W'(CNT_MIN)) begin
			cfg_count = CNT_W'(CNT_MIN);
		end else if (cfg_wdata > CNT_W'(CNT_LIMIT)) begin
			cfg_count = CNT_W'(CNT_LIMIT);
		end else begin
			cfg_count = cfg_wdata;
		end
		cfg_span = span_of(cfg_count);
		cfg_low = CNT_W'(({1'b0, cfg_count} << 1) - {1'b0, cfg_span});
	end

	// memory ports
	always_comb begin
		leaf_req = '0;
		node_req = '0;
		leaf_req.we = item_fire && leaf_in_range
			&& (item.action == ACT_LOAD || item.action == ACT_UPDATE);
		leaf_req.waddr = item.leaf;
		leaf_req.wdata = item.value;
		unique case (state_q)
			ST_BCHK: begin
				leaf_req.raddr = bi_lo;
			end
			ST_BKA: begin
				leaf_req.raddr = bi_next;
			end
			ST_BKB: begin
				node_req.we = 1'b1;
				node_req.waddr = pair_node;
				node_req.wdata = pair_less ? bi_next : bi_lo;
			end
			ST_CLIMB: begin
				node_req.raddr = q_q;
				node_req.we = store_here;
				node_req.waddr = q_q;
				node_req.wdata = cand_q;
			end
			ST_CNODE: begin
				leaf_req.raddr = node_rdata;
			end
			ST_CKEY: begin
				node_req.we = climb_less;
				node_req.waddr = q_q;
				node_req.wdata = cand_q;
			end
			ST_DUMP: begin
				node_req.raddr = dk_q[NODE_W-1:0];
				leaf_req.raddr = node_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= CNT_W'(CNT_LIMIT);
			span_q <= span_of(CNT_W'(CNT_LIMIT));
			low_q <= CNT_W'(2 * CNT_LIMIT) - span_of(CNT_W'(CNT_LIMIT));
			nvalid_q <= '0;
			building_q <= 1'b0;
			bi_q <= '0;
			dk_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= dump_issue;
			v_s2 <= v_s1;
			if (dump_issue) begin
				dk_q <= dk_q + CNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					dk_q <= '0;
					if (item_fire) begin
						unique case (item.action)
							ACT_BUILD: begin
								nvalid_q <= '0;
								bi_q <= '0;
								building_q <= 1'b1;
								state_q <= ST_BCHK;
							end
							ACT_UPDATE: begin
								if (leaf_in_range) begin
									building_q <= 1'b0;
									state_q <= ST_CLIMB;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_BCHK: begin
					state_q <= (bi_q < count_q) ? ST_BKA : ST_DUMP;
				end
				ST_BKA: begin
					if (single) begin
						bi_q <= bi_q + CNT_W'(1);
						state_q <= ST_CLIMB;
					end else begin
						state_q <= ST_BKB;
					end
				end
				ST_BKB: begin
					nvalid_q[pair_node] <= 1'b1;
					bi_q <= bi_q + CNT_W'(2);
					state_q <= ST_CLIMB;
				end
				ST_CLIMB: begin
					if (store_here) begin
						nvalid_q[q_q] <= 1'b1;
						state_q <= building_q ? ST_BCHK : ST_DUMP;
					end else begin
						state_q <= ST_CNODE;
					end
				end
				ST_CNODE: begin
					state_q <= ST_CKEY;
				end
				ST_CKEY: begin
					state_q <= ST_CLIMB;
				end
				ST_DUMP: begin
					if (dump_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				count_q <= cfg_count;
				span_q <= cfg_span;
				low_q <= cfg_low;
				nvalid_q <= '0;
			end
		end
	end

	// candidate and dump pipeline payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cand_q <= item.leaf;
				cand_key_q <= item.value;
				q_q <= parent_of(item.leaf, span_q, low_q);
			end
			ST_BKA: begin
				key_a_q <= leaf_rdata;
				if (single) begin
					cand_q <= bi_lo;
					cand_key_q <= leaf_rdata;
					q_q <= pair_node;
				end
			end
			ST_BKB: begin
				cand_q <= pair_less ? bi_lo : bi_next;
				cand_key_q <= pair_less ? key_a_q : leaf_rdata;
				q_q <= pair_node >> 1;
			end
			ST_CNODE: begin
				stored_q <= node_rdata;
			end
			ST_CKEY: begin
				if (climb_less) begin
					cand_q <= stored_q;
					cand_key_q <= leaf_rdata;
				end
				q_q <= q_q >> 1;
			end
			default: begin
			end
		endcase
		idx_s1 <= dk_q[NODE_W-1:0];
		last_s1 <= (dk_q + CNT_W'(1)) == count_q;
		nv_s1 <= nvalid_q[dk_q[NODE_W-1:0]];
		idx_s2 <= idx_s1;
		last_s2 <= last_s1;
		nv_s2 <= nv_s1;
	end

	assign push_vld = v_s2;
	assign push_word.node_value = nv_s2 ? leaf_rdata : '0;
	assign push_word.node_index = idx_s2;
	assign push_word.last = last_s2;
endmodule
`default_nettype wire

// ----- src/ltr_out_fifo.sv -----
// small output queue that decouples the node dump from the result channel
// depends on ltr_pkg, ltr_result_if
`default_nettype none
module ltr_out_fifo (
	input logic clk,
	input logic arst_n,
	input logic push_vld,
	input ltr_pkg::out_word_t push_word,
	ltr_result_if.source result,
	output logic [ltr_pkg::FIFO_CNT_W-1:0] cnt
);
	import ltr_pkg::*;

	out_word_t mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_q;
	logic [FIFO_PTR_W-1:0] rd_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic pop;
	out_word_t head;

	assign pop = result.valid && result.ready;
	assign head = mem_q[rd_q];
	assign result.valid = (cnt_q != '0);
	assign result.node_value = head.node_value;
	assign result.node_index = head.node_index;
	assign result.last = head.last;
	assign cnt = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push_vld) begin
				wr_q <= wr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + FIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + FIFO_CNT_W'(push_vld) - FIFO_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_vld) begin
			mem_q[wr_q] <= push_word;
		end
	end
endmodule
`default_nettype wire

// ----- src/loser_tree_replay_top.sv -----
// top level of the loser tree replay block
// depends on ltr_pkg, ltr_item_if, ltr_result_if, ltr_ram, ltr_ctrl, ltr_out_fifo
//
// channel  dir  word                               handshake
// item     in   action, leaf, value                valid/ready
// result   out  node_value, node_index, last       valid/ready
// cfg      in   leaf_count                         cfg_we, no ready
//
// load: a leaf ram write; update: CLIMB, CNODE, CKEY per occupied level, store, then the dump
// build: BCHK, BKA and BKB per leaf pair plus its climb, then the dump
// dump: one node a cycle while the output queue has room, through the node ram then the leaf ram
// no clearing pass after reset; a four word output queue absorbs result stalls
`default_nettype none
`include "loser_tree_replay_top_defines.svh"
module loser_tree_replay_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ltr_pkg::CNT_W-1:0] cfg_wdata,
	ltr_item_if.sink item,
	ltr_result_if.source result
);
	import ltr_pkg::*;

	leaf_req_t leaf_req;
	node_req_t node_req;
	logic [KEY_W-1:0] leaf_rdata;
	logic [NODE_W-1:0] node_rdata;
	logic [FIFO_CNT_W-1:0] fifo_cnt;
	logic push_vld;
	out_word_t push_word;

	ltr_ram #(
		.WIDTH(KEY_W),
		.DEPTH(MAX_LEAVES)
	) u_leaf_ram (
		.clk(clk),
		.we(leaf_req.we),
		.waddr(leaf_req.waddr),
		.wdata(leaf_req.wdata),
		.raddr(leaf_req.raddr),
		.rdata(leaf_rdata)
	);

	ltr_ram #(
		.WIDTH(NODE_W),
		.DEPTH(MAX_LEAVES)
	) u_node_ram (
		.clk(clk),
		.we(node_req.we),
		.waddr(node_req.waddr),
		.wdata(node_req.wdata),
		.raddr(node_req.raddr),
		.rdata(node_rdata)
	);

	ltr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item(item),
		.leaf_req(leaf_req),
		.leaf_rdata(leaf_rdata),
		.node_req(node_req),
		.node_rdata(node_rdata),
		.fifo_cnt(fifo_cnt),
		.push_vld(push_vld),
		.push_word(push_word)
	);

	ltr_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_vld(push_vld),
		.push_word(push_word),
		.result(result),
		.cnt(fifo_cnt)
	);

	`LTR_CHECK_ALWAYS(a_fifo_bound, !arst_n || (fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH)))
	`LTR_CHECK(a_no_overflow, push_vld |-> (fifo_cnt != FIFO_CNT_W'(FIFO_DEPTH)))
	`LTR_CHECK(a_no_push_idle, push_vld |-> !item.ready)
	`LTR_CHECK(a_single_writer, leaf_req.we |-> !node_req.we)
endmodule
`default_nettype wire

// ----- verif/loser_tree_replay_top_tb.sv -----
// testbench for loser_tree_replay_top: loads, builds and replays against a local tournament model
// depends on ltr_pkg, ltr_item_if, ltr_result_if and the loser_tree_replay_top rtl
`timescale 1ns / 100ps
module loser_tree_replay_top_tb;
	import ltr_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 5;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_GAP = 17;
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
	localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

	typedef struct {
		logic [ACT_W-1:0] action;
		logic [NODE_W-1:0] leaf;
		logic signed [KEY_W-1:0] value;
		int gap;
		bit drain;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	ltr_item_if item_ch ();
	ltr_result_if result_ch ();

	loser_tree_replay_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item(item_ch),
		.result(result_ch)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// tournament state
	int n_leaves;
	int span;
	int low_grp;
	logic signed [KEY_W-1:0] key_store [MAX_LEAVES];
	logic [NODE_W-1:0] loser_at [MAX_LEAVES];
	bit held [MAX_LEAVES];

	stim_t item_q [$];
	out_word_t node_dump_q [$];

	bit send_calm;
	bit recv_calm;
	bit have_next;
	bit in_flight;
	int gap_left;
	int stall_left;
	stim_t next_word;

	int errors;
	int cycles;
	int n_sent;
	int n_loads;
	int n_builds;
	int n_updates;
	int n_skipped;
	int n_words;
	int n_settings;

	function automatic void set_leaf_count(input logic [CNT_W-1:0] v);
		int c;
		int t;
		c = v;
		if (c < CNT_MIN) c = CNT_MIN;
		if (c > CNT_LIMIT) c = CNT_LIMIT;
		t = 1;
		while (t < c) t = t * 2;
		n_leaves = c;
		span = t;
		low_grp = 2 * c - t;
		foreach (held[k]) held[k] = 1'b0;
	endfunction

	function automatic int leaf_slot(input int i);
		if (i < low_grp) return i + span;
		return i - low_grp / 2 + span / 2;
	endfunction

	// carry a candidate up, keeping the larger key at each occupied node
	function automatic void replay_up(input int start, input logic [NODE_W-1:0] cand);
		int p;
		int q;
		bit done;
		logic [NODE_W-1:0] t;
		p = start;
		done = 1'b0;
		while (!done) begin
			q = p % MAX_LEAVES;
			if (q == 0 || !held[q]) begin
				loser_at[q] = cand;
				held[q] = 1'b1;
				done = 1'b1;
			end else begin
				if (key_store[loser_at[q]] < key_store[cand]) begin
					t = loser_at[q];
					loser_at[q] = cand;
					cand = t;
				end
				p = q >> 1;
			end
		end
	endfunction

	function automatic void play_match(input int i);
		int p;
		int win;
		int lose;
		p = leaf_slot(i) / 2;
		if (key_store[i] < key_store[i + 1]) begin
			win = i;
			lose = i + 1;
		end else begin
			win = i + 1;
			lose = i;
		end
		loser_at[p % MAX_LEAVES] = NODE_W'(lose);
		held[p % MAX_LEAVES] = 1'b1;
		replay_up(p >> 1, NODE_W'(win));
	endfunction

	function automatic void run_tournament();
		int i;
		foreach (held[k]) held[k] = 1'b0;
		i = 0;
		while (i < low_grp) begin
			play_match(i);
			i += 2;
		end
		if (n_leaves % 2 == 1) begin
			replay_up(leaf_slot(i) / 2, NODE_W'(i));
			i++;
		end
		while (i < n_leaves) begin
			play_match(i);
			i += 2;
		end
	endfunction

	function automatic void queue_node_dump();
		out_word_t w;
		for (int k = 0; k < n_leaves; k++) begin
			w.node_value = held[k] ? key_store[loser_at[k]] : '0;
			w.node_index = NODE_W'(k);
			w.last = (k == n_leaves - 1);
			node_dump_q.push_back(w);
		end
	endfunction

	function automatic void apply_item(input logic [ACT_W-1:0] act, input logic [NODE_W-1:0] leaf,
		input logic signed [KEY_W-1:0] key);
		if (act == ACT_BUILD) begin
			run_tournament();
			queue_node_dump();
			n_builds++;
			return;
		end
		if (act == ACT_SPARE || leaf >= n_leaves) begin
			n_skipped++;
			return;
		end
		key_store[leaf] = key;
		if (act == ACT_LOAD) begin
			n_loads++;
			return;
		end
		replay_up(leaf_slot(leaf) / 2, leaf);
		queue_node_dump();
		n_updates++;
	endfunction

	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 7))
			0: begin
				return KEY_MIN;
			end
			1: begin
				return KEY_MAX;
			end
			2, 3: begin
				return KEY_W'($urandom_range(0, 6)) - KEY_W'(3);
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	function automatic void queue_item(input logic [ACT_W-1:0] act, input int leaf_no,
		input logic signed [KEY_W-1:0] key, input bit drain);
		stim_t s;
		if ($urandom_range(0, 11) == 0) send_calm = !send_calm;
		s.action = act;
		s.leaf = NODE_W'(leaf_no);
		s.value = key;
		s.drain = drain;
		s.gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
		item_q.push_back(s);
		n_sent++;
	endfunction

	function automatic void queue_random_ops(input int count);
		int r;
		bit drain;
		for (int j = 0; j < count; j++) begin
			r = $urandom_range(0, 19);
			drain = ($urandom_range(0, 14) == 0);
			if (r < 4) begin
				queue_item(ACT_LOAD, $urandom_range(0, n_leaves - 1), pick_key(), drain);
			end else if (r < 12) begin
				queue_item(ACT_UPDATE, $urandom_range(0, n_leaves - 1), pick_key(), drain);
			end else if (r < 14) begin
				queue_item(ACT_BUILD, $urandom_range(0, MAX_LEAVES - 1), $urandom, drain);
			end else if (r < 16 && n_leaves < MAX_LEAVES) begin
				queue_item($urandom_range(0, 1) ? ACT_UPDATE : ACT_LOAD,
					$urandom_range(n_leaves, MAX_LEAVES - 1), pick_key(), drain);
			end else if (r == 16) begin
				queue_item(ACT_SPARE, $urandom_range(0, MAX_LEAVES - 1), $urandom, drain);
			end else begin
				queue_item(ACT_UPDATE, $urandom_range(0, n_leaves - 1),
					$urandom_range(0, 1) ? KEY_MIN : KEY_MAX, drain);
			end
		end
	endfunction

	task automatic wait_idle();
		while (item_q.size() != 0 || have_next || in_flight || node_dump_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_leaf_count(input logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		set_leaf_count(v);
		n_settings++;
	endtask

	// item driver
	always @(posedge clk or negedge arst_n) begin : item_drive
		bit drive;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			item_ch.action <= ACT_LOAD;
			item_ch.leaf <= '0;
			item_ch.value <= '0;
			have_next = 1'b0;
			in_flight = 1'b0;
			gap_left = 0;
		end else begin
			drive = item_ch.valid;
			if (item_ch.valid && item_ch.ready) begin
				apply_item(item_ch.action, item_ch.leaf, item_ch.value);
				drive = 1'b0;
			end
			if (!drive) begin
				if (!have_next && item_q.size() > 0) begin
					next_word = item_q.pop_front();
					gap_left = next_word.gap;
					have_next = 1'b1;
				end
				if (have_next) begin
					if (gap_left > 0) begin
						gap_left--;
					end else if (!next_word.drain || node_dump_q.size() == 0) begin
						item_ch.action <= next_word.action;
						item_ch.leaf <= next_word.leaf;
						item_ch.value <= next_word.value;
						have_next = 1'b0;
						drive = 1'b1;
					end
				end
			end
			in_flight = drive;
			item_ch.valid <= drive;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin : result_watch
		out_word_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				n_words++;
				if (node_dump_q.size() == 0) begin
					$display("%0t: unexpected word, actual node %0d value %0d last %0b", $time,
						result_ch.node_index, result_ch.node_value, result_ch.last);
					errors++;
				end else begin
					want = node_dump_q.pop_front();
					if (result_ch.node_value !== want.node_value) begin
						$display("%0t: node_value mismatch, expected %0d actual %0d", $time,
							want.node_value, result_ch.node_value);
						errors++;
					end
					if (result_ch.node_index !== want.node_index) begin
						$display("%0t: node_index mismatch, expected %0d actual %0d", $time,
							want.node_index, result_ch.node_index);
						errors++;
					end
					if (result_ch.last !== want.last) begin
						$display("%0t: last mismatch, expected %0b actual %0b", $time,
							want.last, result_ch.last);
						errors++;
					end
				end
				if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
				stall_left = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d words outstanding", $time, node_dump_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [CNT_W-1:0] counts [9];
		counts = '{5'd31, 5'd3, 5'd1, 5'd9, 5'd16, 5'd5, 5'd12, 5'd17, 5'd7};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.action = ACT_LOAD;
		item_ch.leaf = '0;
		item_ch.value = '0;
		result_ch.ready = 1'b0;
		foreach (loser_at[k]) loser_at[k] = '0;
		set_leaf_count(CNT_W'(MAX_LEAVES));
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// two leaves: extremes, replay before any build, ties, ignored words
		write_leaf_count(CNT_W'(0));
		queue_item(ACT_LOAD, 0, KEY_MIN, 1'b0);
		queue_item(ACT_LOAD, 1, KEY_MAX, 1'b0);
		queue_item(ACT_UPDATE, 1, KEY_MAX, 1'b0);
		queue_item(ACT_BUILD, 15, KEY_MIN, 1'b0);
		queue_item(ACT_LOAD, 0, 7, 1'b0);
		queue_item(ACT_LOAD, 1, 7, 1'b0);
		queue_item(ACT_BUILD, 0, 0, 1'b0);
		queue_item(ACT_UPDATE, 0, -1, 1'b0);
		queue_item(ACT_UPDATE, 1, -1, 1'b0);
		queue_item(ACT_LOAD, 2, 0, 1'b0);
		queue_item(ACT_UPDATE, 15, KEY_MIN, 1'b0);
		queue_item(ACT_SPARE, 0, KEY_MAX, 1'b0);
		queue_item(ACT_UPDATE, 0, KEY_MIN, 1'b1);
		queue_item(ACT_BUILD, 5, 0, 1'b0);

		foreach (counts[p]) begin
			wait_idle();
			write_leaf_count(counts[p]);
			if (p == 0) begin
				for (int i = 0; i < n_leaves; i++)
					queue_item(ACT_LOAD, i, pick_key(), 1'b0);
			end
			queue_random_ops(3);
			queue_item(ACT_BUILD, $urandom_range(0, MAX_LEAVES - 1), $urandom, p == 1);
			queue_random_ops(5);
		end
		wait_idle();

		$display("run covered %0d words in: %0d loads, %0d builds, %0d updates, %0d ignored",
			n_sent, n_loads, n_builds, n_updates, n_skipped);
		$display("%0d node words checked over %0d leaf count settings, %0d mismatches",
			n_words, n_settings, errors);
		if (errors == 0 && node_dump_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
